// ===== rtl/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg : shared types, widths and tables
// constants, sideband structs and rounding helpers for the rotation matrix
// to euler angle pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

    localparam int MATRIX_FRAC_BITS = 14;
    localparam int ANGLE_FRAC_BITS  = 12;
    localparam int QUAT_FRAC_BITS   = 30;
    localparam int STEPS            = 31;
    localparam int STEP_W           = 5;
    localparam int RAD_W            = 62;
    localparam int ROOT_W           = 31;
    localparam int REM_W            = 33;
    localparam int DIV_W            = 33;
    localparam int Q_W              = 32;
    localparam int CW               = 37;
    localparam int ZW               = 35;
    localparam int MAG_W            = 17;
    localparam int LANES            = 3;

    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [Q_W-1:0] Q_ONE = 32'sd1073741824;

    typedef struct packed {
        logic                          valid;
        logic                          degen;
        logic [LANES-1:0]              neg;
        logic [LANES-1:0][MAG_W-1:0]   mag;
    } t_sba;

    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } t_sbd;

    typedef struct packed {
        logic             valid;
        logic             degen;
    } t_sbv;

    typedef struct packed {
        logic                   valid;
        logic                   degen;
        logic signed [Q_W-1:0]  t1;
        logic signed [ZW-1:0]   py;
        logic signed [ZW-1:0]   px;
        logic signed [ZW-1:0]   ry;
        logic signed [ZW-1:0]   rx;
    } t_sbb;

    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [LANES-1:0] zero;
    } t_sbc;

    function automatic logic [29:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // half away from zero, product back to q.30
    function automatic logic signed [Q_W-1:0] round_q30(input logic signed [63:0] p);
        logic [63:0] m;
        logic [63:0] r;
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + 64'(64'd1 << (QUAT_FRAC_BITS - 1))) >> QUAT_FRAC_BITS;
        return p[63] ? -Q_W'(r) : Q_W'(r);
    endfunction

    // half away from zero, q.30 angle to output scale
    function automatic logic signed [16:0] round_angle(input logic signed [ZW-1:0] z);
        logic [ZW:0] m;
        logic [ZW:0] r;
        m = z[ZW-1] ? (ZW+1)'(-(ZW+1)'(z)) : (ZW+1)'(z);
        r = (m + (ZW+1)'(1 << (QUAT_FRAC_BITS - ANGLE_FRAC_BITS - 1)))
            >> (QUAT_FRAC_BITS - ANGLE_FRAC_BITS);
        return z[ZW-1] ? -17'(r) : 17'(r);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rme_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rme_sqrt_cell : one digit of the square root chain
// takes two radicand bits, forms one root bit and hands on the remainder
// ----------------------------------------------------------------------------
`default_nettype none

module rme_sqrt_cell (
    input  wire logic                        i_clk,
    input  wire logic [rme_pkg::REM_W-1:0]   i_rem,
    input  wire logic [rme_pkg::ROOT_W-1:0]  i_root,
    input  wire logic [rme_pkg::RAD_W-1:0]   i_rad,
    output logic      [rme_pkg::REM_W-1:0]   o_rem,
    output logic      [rme_pkg::ROOT_W-1:0]  o_root,
    output logic      [rme_pkg::RAD_W-1:0]   o_rad
);

    logic [rme_pkg::REM_W+1:0] w_acc;
    logic [rme_pkg::REM_W+1:0] w_trial;
    logic [rme_pkg::REM_W+1:0] w_diff;
    logic                      w_ge;
    logic [rme_pkg::REM_W-1:0]  r_rem;
    logic [rme_pkg::ROOT_W-1:0] r_root;
    logic [rme_pkg::RAD_W-1:0]  r_rad;

    always_comb begin
        w_acc   = {i_rem, i_rad[rme_pkg::RAD_W-1 -: 2]};
        w_trial = {2'b00, i_root, 2'b01};
        w_ge    = (w_acc >= w_trial);
        w_diff  = w_acc - w_trial;
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= w_ge ? w_diff[rme_pkg::REM_W-1:0] : w_acc[rme_pkg::REM_W-1:0];
        r_root <= {i_root[rme_pkg::ROOT_W-2:0], w_ge};
        r_rad  <= {i_rad[rme_pkg::RAD_W-3:0], 2'b00};
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

`default_nettype wire

// ===== rtl/rme_div_cell.sv =====
// ----------------------------------------------------------------------------
// rme_div_cell : one quotient bit of the restoring divider chain
// shifts the partial remainder, subtracts the divisor when it fits
// ----------------------------------------------------------------------------
`default_nettype none

module rme_div_cell (
    input  wire logic                        i_clk,
    input  wire logic [rme_pkg::DIV_W-1:0]   i_p,
    input  wire logic [rme_pkg::DIV_W-1:0]   i_d,
    input  wire logic [rme_pkg::ROOT_W-1:0]  i_q,
    output logic      [rme_pkg::DIV_W-1:0]   o_p,
    output logic      [rme_pkg::DIV_W-1:0]   o_d,
    output logic      [rme_pkg::ROOT_W-1:0]  o_q
);

    logic [rme_pkg::DIV_W:0] w_sh;
    logic [rme_pkg::DIV_W:0] w_diff;
    logic                    w_ge;
    logic [rme_pkg::DIV_W-1:0]  r_p;
    logic [rme_pkg::DIV_W-1:0]  r_d;
    logic [rme_pkg::ROOT_W-1:0] r_q;

    always_comb begin
        w_sh   = {i_p, 1'b0};
        w_ge   = (w_sh >= {1'b0, i_d});
        w_diff = w_sh - {1'b0, i_d};
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_ge ? w_diff[rme_pkg::DIV_W-1:0] : w_sh[rme_pkg::DIV_W-1:0];
        r_d <= i_d;
        r_q <= {i_q[rme_pkg::ROOT_W-2:0], w_ge};
    end

    assign o_p = r_p;
    assign o_d = r_d;
    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== rtl/rme_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// rme_cordic_cell : one vectoring micro-rotation
// rotates towards the x axis and accumulates the table angle
// ----------------------------------------------------------------------------
`default_nettype none

module rme_cordic_cell (
    input  wire logic                              i_clk,
    input  wire logic        [rme_pkg::STEP_W-1:0] i_step,
    input  wire logic signed [rme_pkg::CW-1:0]     i_x,
    input  wire logic signed [rme_pkg::CW-1:0]     i_y,
    input  wire logic signed [rme_pkg::ZW-1:0]     i_z,
    output logic      signed [rme_pkg::CW-1:0]     o_x,
    output logic      signed [rme_pkg::CW-1:0]     o_y,
    output logic      signed [rme_pkg::ZW-1:0]     o_z
);

    logic signed [rme_pkg::CW-1:0] w_xs;
    logic signed [rme_pkg::CW-1:0] w_ys;
    logic signed [rme_pkg::ZW-1:0] w_tab;
    logic signed [rme_pkg::CW-1:0] r_x;
    logic signed [rme_pkg::CW-1:0] r_y;
    logic signed [rme_pkg::ZW-1:0] r_z;

    always_comb begin
        w_xs  = i_x >>> i_step;
        w_ys  = i_y >>> i_step;
        w_tab = $signed({5'b0, rme_pkg::atan_entry(i_step)});
    end

    always_ff @(posedge i_clk) begin
        if (i_y > 0) begin
            r_x <= i_x + w_ys;
            r_y <= i_y - w_xs;
            r_z <= i_z + w_tab;
        end else begin
            r_x <= i_x - w_ys;
            r_y <= i_y + w_xs;
            r_z <= i_z - w_tab;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

`default_nettype wire

// ===== rtl/rotation_matrix_to_euler_top.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_top : rotation matrix to yaw, pitch and roll
// quaternion from the matrix, then arcsine and arctangents, fully pipelined
// ----------------------------------------------------------------------------
// A new matrix request is taken in every clock cycle (busy stays low) and its
// angles appear on the result ports at the end of the pipeline, for one cycle,
// marked by o_valid. The receiver cannot stall and must take each result as it comes.
// The pipeline is made of the four 31-cell chains and the single-stage steps
// around them: square root of one plus the trace, the three restoring
// divides, the square root for the yaw cosine term and the CORDIC angle cells.
`default_nettype none

module rotation_matrix_to_euler_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_r00,
    input  wire logic signed [15:0] i_r01,
    input  wire logic signed [15:0] i_r02,
    input  wire logic signed [15:0] i_r10,
    input  wire logic signed [15:0] i_r11,
    input  wire logic signed [15:0] i_r12,
    input  wire logic signed [15:0] i_r20,
    input  wire logic signed [15:0] i_r21,
    input  wire logic signed [15:0] i_r22,
    output logic                    o_valid,
    output logic signed [13:0]      o_yaw_angle,
    output logic signed [14:0]      o_pitch_angle,
    output logic signed [14:0]      o_roll_angle,
    output logic                    o_degenerate
);

    localparam int N  = rme_pkg::STEPS;
    localparam int NL = rme_pkg::LANES;

    assign busy = 1'b0;

    // entry stage
    logic signed [17:0]              w_s;
    logic [rme_pkg::MAG_W-1:0]       w_sc;
    logic signed [rme_pkg::MAG_W-1:0] w_dif [NL];
    rme_pkg::t_sba                   n_sba0;
    logic [rme_pkg::RAD_W-1:0]       r_rad;
    rme_pkg::t_sba                   r_sba0;

    always_comb begin
        w_s = 18'sd16384 + 18'(i_r00) + 18'(i_r11) + 18'(i_r22);
        w_sc = (w_s > 18'sd65536) ? 17'd65536 : w_s[16:0];
        w_dif[0] = 17'(i_r21) - 17'(i_r12);
        w_dif[1] = 17'(i_r02) - 17'(i_r20);
        w_dif[2] = 17'(i_r10) - 17'(i_r01);
        n_sba0.valid = start;
        n_sba0.degen = (w_s <= 18'sd0);
        for (int l = 0; l < NL; l++) begin
            n_sba0.neg[l] = w_dif[l][16];
            n_sba0.mag[l] = w_dif[l][16] ? 17'(-w_dif[l]) : 17'(w_dif[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad <= {1'b0, w_sc, 44'b0};
        if (!i_rst_n) begin
            r_sba0 <= '0;
        end else begin
            r_sba0 <= n_sba0;
        end
    end

    // square root chain for q0
    logic [rme_pkg::REM_W-1:0]  w_arem  [N+1];
    logic [rme_pkg::ROOT_W-1:0] w_aroot [N+1];
    logic [rme_pkg::RAD_W-1:0]  w_arad  [N+1];
    rme_pkg::t_sba              r_sba   [N];

    assign w_arem[0]  = '0;
    assign w_aroot[0] = '0;
    assign w_arad[0]  = r_rad;

    for (genvar k = 0; k < N; k++) begin : g_sqa
        rme_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_arem[k]),
            .i_root (w_aroot[k]),
            .i_rad  (w_arad[k]),
            .o_rem  (w_arem[k+1]),
            .o_root (w_aroot[k+1]),
            .o_rad  (w_arad[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_sba[k] <= '0;
        end else begin
            r_sba[0] <= r_sba0;
            for (int k = 1; k < N; k++) r_sba[k] <= r_sba[k-1];
        end
    end

    // divider set-up
    logic [rme_pkg::DIV_W-1:0] w_d;
    logic [rme_pkg::DIV_W-1:0] w_p0 [NL];
    rme_pkg::t_sbd             n_sbd0;
    logic [rme_pkg::DIV_W-1:0] r_d0;
    logic [rme_pkg::DIV_W-1:0] r_p0 [NL];
    rme_pkg::t_sbd             r_sbd0;

    always_comb begin
        w_d = {w_aroot[N], 2'b00};
        n_sbd0.valid = r_sba[N-1].valid;
        n_sbd0.degen = r_sba[N-1].degen;
        n_sbd0.neg   = r_sba[N-1].neg;
        for (int l = 0; l < NL; l++) begin
            w_p0[l] = {1'b0, r_sba[N-1].mag[l], 15'b0};
            n_sbd0.ovf[l] = (w_p0[l] >= w_d);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= w_d;
        for (int l = 0; l < NL; l++) r_p0[l] <= w_p0[l];
        if (!i_rst_n) begin
            r_sbd0 <= '0;
        end else begin
            r_sbd0 <= n_sbd0;
        end
    end

    // divider chains, one per vector part
    logic [rme_pkg::DIV_W-1:0]  w_dp [NL][N+1];
    logic [rme_pkg::DIV_W-1:0]  w_dd [NL][N+1];
    logic [rme_pkg::ROOT_W-1:0] w_dq [NL][N+1];
    rme_pkg::t_sbd              r_sbd [N];

    for (genvar l = 0; l < NL; l++) begin : g_lane_div
        assign w_dp[l][0] = r_p0[l];
        assign w_dd[l][0] = r_d0;
        assign w_dq[l][0] = '0;
        for (genvar k = 0; k < N; k++) begin : g_div
            rme_div_cell u_cell (
                .i_clk (i_clk),
                .i_p   (w_dp[l][k]),
                .i_d   (w_dd[l][k]),
                .i_q   (w_dq[l][k]),
                .o_p   (w_dp[l][k+1]),
                .o_d   (w_dd[l][k+1]),
                .o_q   (w_dq[l][k+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_sbd[k] <= '0;
        end else begin
            r_sbd[0] <= r_sbd0;
            for (int k = 1; k < N; k++) r_sbd[k] <= r_sbd[k-1];
        end
    end

    // saturate and sign the quaternion parts
    logic signed [rme_pkg::Q_W-1:0] w_qv [NL];
    logic signed [rme_pkg::Q_W-1:0] r_q0;
    logic signed [rme_pkg::Q_W-1:0] r_q1;
    logic signed [rme_pkg::Q_W-1:0] r_q2;
    logic signed [rme_pkg::Q_W-1:0] r_q3;
    rme_pkg::t_sbv                  r_sbq;

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            logic signed [rme_pkg::Q_W-1:0] v_mag;
            v_mag = (r_sbd[N-1].ovf[l] || (w_dq[l][N] > 31'd1073741824))
                  ? rme_pkg::Q_ONE : $signed({1'b0, w_dq[l][N]});
            w_qv[l] = r_sbd[N-1].neg[l] ? -v_mag : v_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= $signed({1'b0, w_dd[0][N][rme_pkg::DIV_W-1:2]});
        r_q1 <= w_qv[0];
        r_q2 <= w_qv[1];
        r_q3 <= w_qv[2];
        if (!i_rst_n) begin
            r_sbq <= '0;
        end else begin
            r_sbq.valid <= r_sbd[N-1].valid;
            r_sbq.degen <= r_sbd[N-1].degen;
        end
    end

    // products
    logic signed [63:0] r_p02, r_p13, r_p01, r_p23, r_p00;
    logic signed [63:0] r_p11, r_p22, r_p33, r_p03, r_p12;
    rme_pkg::t_sbv      r_sbm;

    always_ff @(posedge i_clk) begin
        r_p02 <= r_q0 * r_q2;
        r_p13 <= r_q1 * r_q3;
        r_p01 <= r_q0 * r_q1;
        r_p23 <= r_q2 * r_q3;
        r_p00 <= r_q0 * r_q0;
        r_p11 <= r_q1 * r_q1;
        r_p22 <= r_q2 * r_q2;
        r_p33 <= r_q3 * r_q3;
        r_p03 <= r_q0 * r_q3;
        r_p12 <= r_q1 * r_q2;
        if (!i_rst_n) begin
            r_sbm <= '0;
        end else begin
            r_sbm <= r_sbq;
        end
    end

    // rounding
    logic signed [rme_pkg::Q_W-1:0] r_m02, r_m13, r_m01, r_m23, r_m00;
    logic signed [rme_pkg::Q_W-1:0] r_m11, r_m22, r_m33, r_m03, r_m12;
    rme_pkg::t_sbv                  r_sbr;

    always_ff @(posedge i_clk) begin
        r_m02 <= rme_pkg::round_q30(r_p02);
        r_m13 <= rme_pkg::round_q30(r_p13);
        r_m01 <= rme_pkg::round_q30(r_p01);
        r_m23 <= rme_pkg::round_q30(r_p23);
        r_m00 <= rme_pkg::round_q30(r_p00);
        r_m11 <= rme_pkg::round_q30(r_p11);
        r_m22 <= rme_pkg::round_q30(r_p22);
        r_m33 <= rme_pkg::round_q30(r_p33);
        r_m03 <= rme_pkg::round_q30(r_p03);
        r_m12 <= rme_pkg::round_q30(r_p12);
        if (!i_rst_n) begin
            r_sbr <= '0;
        end else begin
            r_sbr <= r_sbm;
        end
    end

    // angle terms
    logic signed [33:0]             w_t1w;
    logic signed [rme_pkg::Q_W-1:0] w_t1;
    rme_pkg::t_sbb                  r_sbt;

    always_comb begin
        w_t1w = 34'sd2 * (34'(r_m02) + 34'(r_m13));
        if (w_t1w > 34'sd1073741824) begin
            w_t1 = rme_pkg::Q_ONE;
        end else if (w_t1w < -34'sd1073741824) begin
            w_t1 = -rme_pkg::Q_ONE;
        end else begin
            w_t1 = w_t1w[rme_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbt <= '0;
        end else begin
            r_sbt.valid <= r_sbr.valid;
            r_sbt.degen <= r_sbr.degen;
            r_sbt.t1    <= w_t1;
            r_sbt.py    <= 35'sd2 * (35'(r_m01) - 35'(r_m23));
            r_sbt.px    <= 35'(r_m00) - 35'(r_m11) - 35'(r_m22) + 35'(r_m33);
            r_sbt.ry    <= 35'sd2 * (35'(r_m03) - 35'(r_m12));
            r_sbt.rx    <= 35'(r_m00) + 35'(r_m11) - 35'(r_m22) - 35'(r_m33);
        end
    end

    // radicand for the yaw cosine term
    logic signed [63:0]        w_sq;
    logic [63:0]               w_rad2;
    logic [rme_pkg::RAD_W-1:0] r_rad2;
    rme_pkg::t_sbb             r_sbb0;

    always_comb begin
        w_sq   = r_sbt.t1 * r_sbt.t1;
        w_rad2 = (64'd1 << (2 * rme_pkg::QUAT_FRAC_BITS)) - 64'(w_sq);
    end

    always_ff @(posedge i_clk) begin
        r_rad2 <= w_rad2[rme_pkg::RAD_W-1:0];
        if (!i_rst_n) begin
            r_sbb0 <= '0;
        end else begin
            r_sbb0 <= r_sbt;
        end
    end

    // square root chain for the cosine term
    logic [rme_pkg::REM_W-1:0]  w_brem  [N+1];
    logic [rme_pkg::ROOT_W-1:0] w_broot [N+1];
    logic [rme_pkg::RAD_W-1:0]  w_brad  [N+1];
    rme_pkg::t_sbb              r_sbb   [N];

    assign w_brem[0]  = '0;
    assign w_broot[0] = '0;
    assign w_brad[0]  = r_rad2;

    for (genvar k = 0; k < N; k++) begin : g_sqb
        rme_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rem  (w_brem[k]),
            .i_root (w_broot[k]),
            .i_rad  (w_brad[k]),
            .o_rem  (w_brem[k+1]),
            .o_root (w_broot[k+1]),
            .o_rad  (w_brad[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_sbb[k] <= '0;
        end else begin
            r_sbb[0] <= r_sbb0;
            for (int k = 1; k < N; k++) r_sbb[k] <= r_sbb[k-1];
        end
    end

    // quadrant pre-rotation
    logic signed [rme_pkg::CW-1:0] w_iy [NL];
    logic signed [rme_pkg::CW-1:0] w_ix [NL];
    logic signed [rme_pkg::CW-1:0] r_cx0 [NL];
    logic signed [rme_pkg::CW-1:0] r_cy0 [NL];
    logic signed [rme_pkg::ZW-1:0] r_cz0 [NL];
    rme_pkg::t_sbc                 r_sbc0;

    always_comb begin
        w_iy[rme_pkg::LANE_YAW]   = 37'(r_sbb[N-1].t1);
        w_ix[rme_pkg::LANE_YAW]   = $signed({6'b0, w_broot[N]});
        w_iy[rme_pkg::LANE_PITCH] = 37'(r_sbb[N-1].py);
        w_ix[rme_pkg::LANE_PITCH] = 37'(r_sbb[N-1].px);
        w_iy[rme_pkg::LANE_ROLL]  = 37'(r_sbb[N-1].ry);
        w_ix[rme_pkg::LANE_ROLL]  = 37'(r_sbb[N-1].rx);
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            if (w_ix[l] < 0) begin
                r_cx0[l] <= -w_ix[l];
                r_cy0[l] <= -w_iy[l];
                r_cz0[l] <= (w_iy[l] >= 0) ? rme_pkg::PI_Q30 : -rme_pkg::PI_Q30;
            end else begin
                r_cx0[l] <= w_ix[l];
                r_cy0[l] <= w_iy[l];
                r_cz0[l] <= '0;
            end
        end
        if (!i_rst_n) begin
            r_sbc0 <= '0;
        end else begin
            r_sbc0.valid <= r_sbb[N-1].valid;
            r_sbc0.degen <= r_sbb[N-1].degen;
            for (int l = 0; l < NL; l++) begin
                r_sbc0.zero[l] <= (w_ix[l] == 0) && (w_iy[l] == 0);
            end
        end
    end

    // cordic chains
    logic signed [rme_pkg::CW-1:0] w_cx [NL][N+1];
    logic signed [rme_pkg::CW-1:0] w_cy [NL][N+1];
    logic signed [rme_pkg::ZW-1:0] w_cz [NL][N+1];
    rme_pkg::t_sbc                 r_sbc [N];

    for (genvar l = 0; l < NL; l++) begin : g_lane_cordic
        assign w_cx[l][0] = r_cx0[l];
        assign w_cy[l][0] = r_cy0[l];
        assign w_cz[l][0] = r_cz0[l];
        for (genvar k = 0; k < N; k++) begin : g_cordic
            rme_cordic_cell u_cell (
                .i_clk  (i_clk),
                .i_step (rme_pkg::STEP_W'(k)),
                .i_x    (w_cx[l][k]),
                .i_y    (w_cy[l][k]),
                .i_z    (w_cz[l][k]),
                .o_x    (w_cx[l][k+1]),
                .o_y    (w_cy[l][k+1]),
                .o_z    (w_cz[l][k+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_sbc[k] <= '0;
        end else begin
            r_sbc[0] <= r_sbc0;
            for (int k = 1; k < N; k++) r_sbc[k] <= r_sbc[k-1];
        end
    end

    // result register
    logic signed [16:0] w_ang [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            w_ang[l] = (r_sbc[N-1].zero[l] || r_sbc[N-1].degen)
                     ? 17'sd0 : rme_pkg::round_angle(w_cz[l][N]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_yaw_angle   <= w_ang[rme_pkg::LANE_YAW][13:0];
        o_pitch_angle <= w_ang[rme_pkg::LANE_PITCH][14:0];
        o_roll_angle  <= w_ang[rme_pkg::LANE_ROLL][14:0];
        o_degenerate  <= r_sbc[N-1].degen;
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_sbc[N-1].valid;
        end
    end

    // checks
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_yaw_angle == 0 && o_pitch_angle == 0 && o_roll_angle == 0))
        else $error("degenerate request gave nonzero angles");

    a_q0_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sba[N-1].valid && !r_sba[N-1].degen) |->
        (w_aroot[N] >= 31'd4194304 && w_aroot[N] <= 31'd1073741824))
        else $error("scalar part out of range");

    a_t1_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sbt.valid |-> (r_sbt.t1 <= rme_pkg::Q_ONE && r_sbt.t1 >= -rme_pkg::Q_ONE))
        else $error("sine term escaped its clamp");

endmodule

`default_nettype wire
